// ----- rtl/core/enwa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// enwa_pkg
// Shared widths, codes and interface types of the lambda-move word acceptor.
// ----------------------------------------------------------------------------
package enwa_pkg;

   localparam int DEF_NUM_STATES    = 16;
   localparam int DEF_ALPHABET_SIZE = 256;

   localparam int FUNC_W      = 2;
   localparam int STATE_IDX_W = 4;
   localparam int SYMBOL_W    = 8;
   localparam int MASK_W      = 16;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SYM_WR = 2'd0,
      FUNC_LAM_WR = 2'd1,
      FUNC_WORD   = 2'd2,
      FUNC_QUERY  = 2'd3
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_STATE = 1'b0,
      CSR_FINAL_MASK  = 1'b1
   } csr_index_type;

   // datapath operation selected by the current control word
   typedef enum logic [2:0] {
      OP_NOP    = 3'd0,
      OP_CLEAR  = 3'd1,
      OP_IDLE   = 3'd2,
      OP_START  = 3'd3,
      OP_CLOSE  = 3'd4,
      OP_MOVE   = 3'd5,
      OP_CHECK  = 3'd6,
      OP_RESULT = 3'd7
   } op_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic     accept;
      func_type func;
      logic     in_word;
      logic     scan_done;
      logic     changed;
      logic     query;
      logic     last;
      logic     out_busy;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/enwa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// enwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module enwa_ram #(
   parameter int WIDTH = enwa_pkg::DEF_NUM_STATES,
   parameter int DEPTH = enwa_pkg::DEF_NUM_STATES
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/enwa_useq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// enwa_useq
// Microcode sequencer: step counter, control-word ROM and jump logic.
// ----------------------------------------------------------------------------
module enwa_useq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire enwa_pkg::sts_type sts,
   output enwa_pkg::op_type       op
);
   import enwa_pkg::*;

   typedef enum logic [2:0] {
      C_NONE     = 3'd0,
      C_SCAN     = 3'd1,
      C_CLOSE    = 3'd2,
      C_QUERY    = 3'd3,
      C_NOT_LAST = 3'd4,
      C_OUT_BUSY = 3'd5,
      C_DISPATCH = 3'd6
   } cond_type;

   localparam int PC_W = 4;

   localparam logic [PC_W-1:0] P_CLEAR   = 4'd0;
   localparam logic [PC_W-1:0] P_IDLE    = 4'd1;
   localparam logic [PC_W-1:0] P_START   = 4'd2;
   localparam logic [PC_W-1:0] P_CLOSE_S = 4'd3;
   localparam logic [PC_W-1:0] P_BRANCH  = 4'd4;
   localparam logic [PC_W-1:0] P_MOVE    = 4'd5;
   localparam logic [PC_W-1:0] P_CLOSE_M = 4'd6;
   localparam logic [PC_W-1:0] P_CHECK   = 4'd7;
   localparam logic [PC_W-1:0] P_RESULT  = 4'd8;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic [PC_W-1:0] next;
   } uword_type;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   uword_type       uw;
   logic            take;

   // control store: go to target if condition holds, else next, or dispatch
   always_comb begin
      unique case (pc_ff)
         P_CLEAR:   uw = '{OP_CLEAR,  C_SCAN,     P_CLEAR,   P_IDLE};
         P_IDLE:    uw = '{OP_IDLE,   C_DISPATCH, P_IDLE,    P_IDLE};
         P_START:   uw = '{OP_START,  C_NONE,     P_CLOSE_S, P_CLOSE_S};
         P_CLOSE_S: uw = '{OP_CLOSE,  C_CLOSE,    P_CLOSE_S, P_BRANCH};
         P_BRANCH:  uw = '{OP_NOP,    C_QUERY,    P_RESULT,  P_MOVE};
         P_MOVE:    uw = '{OP_MOVE,   C_SCAN,     P_MOVE,    P_CLOSE_M};
         P_CLOSE_M: uw = '{OP_CLOSE,  C_CLOSE,    P_CLOSE_M, P_CHECK};
         P_CHECK:   uw = '{OP_CHECK,  C_NOT_LAST, P_IDLE,    P_RESULT};
         P_RESULT:  uw = '{OP_RESULT, C_OUT_BUSY, P_RESULT,  P_IDLE};
         default:   uw = '{OP_NOP,    C_NONE,     P_IDLE,    P_IDLE};
      endcase
   end

   always_comb begin
      unique case (uw.cond)
         C_NONE:     take = 1'b0;
         C_SCAN:     take = !sts.scan_done;
         C_CLOSE:    take = !sts.scan_done || sts.changed;
         C_QUERY:    take = sts.query;
         C_NOT_LAST: take = !sts.last;
         C_OUT_BUSY: take = sts.out_busy;
         C_DISPATCH: take = 1'b0;
         default:    take = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = take ? uw.target : uw.next;
      if (uw.cond == C_DISPATCH) begin
         pc_in = P_IDLE;
         if (sts.accept) begin
            unique case (sts.func)
               FUNC_SYM_WR: pc_in = P_IDLE;
               FUNC_LAM_WR: pc_in = P_IDLE;
               FUNC_QUERY:  pc_in = P_START;
               FUNC_WORD:   pc_in = sts.in_word ? P_MOVE : P_START;
               default:     pc_in = P_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= P_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op = uw.op;

endmodule
`default_nettype wire

// ----- rtl/core/enwa_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// enwa_dpath
// Datapath: table RAMs, active set, scan counter, result register, CSRs.
// ----------------------------------------------------------------------------
module enwa_dpath #(
   parameter int NUM_STATES    = enwa_pkg::DEF_NUM_STATES,
   parameter int ALPHABET_SIZE = enwa_pkg::DEF_ALPHABET_SIZE
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire enwa_pkg::op_type                  op,
   output enwa_pkg::sts_type                      sts,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [enwa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic [enwa_pkg::FUNC_W-1:0]       req_tuser,
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [enwa_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [enwa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [enwa_pkg::CSR_DATA_W-1:0]   csr_data
);
   import enwa_pkg::*;

   localparam int SW        = $clog2(NUM_STATES);
   localparam int CW        = SW + 1;
   localparam int SYM_W     = $clog2(ALPHABET_SIZE);
   localparam int AW        = SW + SYM_W;
   localparam int SYM_DEPTH = NUM_STATES * (2 ** SYM_W);

   // request fields
   func_type              req_func;
   logic [STATE_IDX_W-1:0] req_src;
   logic [SYMBOL_W-1:0]   req_sym;
   logic [MASK_W-1:0]     req_succ;
   logic [6:0]            req_src_w;
   logic [SW-1:0]         req_src_idx;
   logic                  req_src_ok;
   logic                  req_sym_ok;
   logic [63:0]           req_succ_w;
   logic [NUM_STATES-1:0] req_succ_n;
   logic                  req_accept;

   // configuration
   logic [STATE_IDX_W-1:0] start_ff;
   logic [MASK_W-1:0]      final_ff;
   logic [6:0]             start_w;
   logic                   start_ok;
   logic [SW-1:0]          start_idx;
   logic [63:0]            final_w;
   logic [NUM_STATES-1:0]  final_n;

   // working state
   logic [NUM_STATES-1:0] set_ff,      set_in;
   logic [NUM_STATES-1:0] acc_ff,      acc_in;
   logic [CW-1:0]         s_ff,        s_in;
   logic                  pend_ff,     pend_in;
   logic [SW-1:0]         rd_idx_ff,   rd_idx_in;
   logic                  changed_ff,  changed_in;
   logic                  dead_ff,     dead_in;
   logic                  in_word_ff,  in_word_in;
   logic [AW-1:0]         clr_ff,      clr_in;
   logic [NUM_STATES-1:0] lam_vld_ff,  lam_vld_in;
   logic [SYM_W-1:0]      sym_idx_ff,  sym_idx_in;
   logic                  sym_ok_ff,   sym_ok_in;
   logic                  last_ff,     last_in;
   logic                  query_ff,    query_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_acc_ff,  rsp_acc_in;
   logic                  rsp_died_ff, rsp_died_in;

   // table access
   logic                  sym_we;
   logic [AW-1:0]         sym_wa;
   logic [NUM_STATES-1:0] sym_wd;
   logic [AW-1:0]         sym_ra;
   logic [NUM_STATES-1:0] sym_rd;
   logic                  lam_we;
   logic [SW-1:0]         lam_ra;
   logic [NUM_STATES-1:0] lam_rd;

   logic                  s_lt;
   logic [SW-1:0]         s_idx;
   logic                  clr_last;
   logic [NUM_STATES-1:0] lam_row;
   logic                  set_hit;
   logic [NUM_STATES-1:0] close_set;
   logic                  close_chg;
   logic [NUM_STATES-1:0] move_acc;
   logic                  rsp_busy;

   assign req_func    = func_type'(req_tuser);
   assign req_src     = req_tdata[3:0];
   assign req_sym     = req_tdata[11:4];
   assign req_succ    = req_tdata[27:12];
   assign req_src_w   = {3'd0, req_src};
   assign req_src_idx = req_src_w[SW-1:0];
   assign req_src_ok  = req_src_w < 7'(NUM_STATES);
   assign req_sym_ok  = {1'b0, req_sym} < 9'(ALPHABET_SIZE);
   assign req_succ_w  = {48'd0, req_succ};
   assign req_succ_n  = req_succ_w[NUM_STATES-1:0];

   assign req_tready = (op == OP_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign start_w   = {3'd0, start_ff};
   assign start_ok  = start_w < 7'(NUM_STATES);
   assign start_idx = start_w[SW-1:0];
   assign final_w   = {48'd0, final_ff};
   assign final_n   = final_w[NUM_STATES-1:0];

   assign s_lt     = s_ff < CW'(NUM_STATES);
   assign s_idx    = s_lt ? s_ff[SW-1:0] : '0;
   assign clr_last = clr_ff == AW'(SYM_DEPTH - 1);
   assign lam_ra   = s_idx;
   assign sym_ra   = {s_idx, sym_idx_ff};

   // row returned by the read issued in the previous cycle
   assign lam_row   = lam_rd & {NUM_STATES{lam_vld_ff[rd_idx_ff]}};
   assign set_hit   = pend_ff && set_ff[rd_idx_ff];
   assign close_set = set_hit ? (set_ff | lam_row) : set_ff;
   assign close_chg = close_set != set_ff;
   assign move_acc  = (set_hit && sym_ok_ff) ? (acc_ff | sym_rd) : acc_ff;

   assign rsp_busy = rsp_valid_ff && !rsp_tready;

   always_comb begin
      set_in       = set_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      pend_in      = 1'b0;
      rd_idx_in    = s_idx;
      changed_in   = changed_ff;
      dead_in      = dead_ff;
      in_word_in   = in_word_ff;
      clr_in       = clr_ff;
      lam_vld_in   = lam_vld_ff;
      sym_idx_in   = sym_idx_ff;
      sym_ok_in    = sym_ok_ff;
      last_in      = last_ff;
      query_in     = query_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_died_in  = rsp_died_ff;
      sym_we       = 1'b0;
      sym_wa       = clr_ff;
      sym_wd       = '0;
      lam_we       = 1'b0;

      unique case (op)
         OP_NOP: begin
         end
         OP_CLEAR: begin
            sym_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         OP_IDLE: begin
            s_in       = '0;
            changed_in = 1'b0;
            acc_in     = '0;
            if (req_accept) begin
               sym_idx_in = req_sym[SYM_W-1:0];
               sym_ok_in  = req_sym_ok;
               last_in    = req_tlast;
               query_in   = (req_func == FUNC_QUERY);
               if (req_func == FUNC_SYM_WR && req_src_ok && req_sym_ok) begin
                  sym_we = 1'b1;
                  sym_wa = {req_src_idx, req_sym[SYM_W-1:0]};
                  sym_wd = req_succ_n;
               end
               if (req_func == FUNC_LAM_WR && req_src_ok) begin
                  lam_we                  = 1'b1;
                  lam_vld_in[req_src_idx] = 1'b1;
               end
            end
         end
         OP_START: begin
            set_in     = start_ok ? (NUM_STATES'(1) << start_idx) : '0;
            dead_in    = 1'b0;
            in_word_in = !query_ff;
         end
         OP_CLOSE: begin
            // grow the set in place; a pass without change ends the closure
            set_in = close_set;
            if (s_lt) begin
               s_in       = s_ff + 1'b1;
               pend_in    = 1'b1;
               changed_in = changed_ff || close_chg;
            end else begin
               s_in       = '0;
               changed_in = 1'b0;
            end
         end
         OP_MOVE: begin
            if (s_lt) begin
               s_in    = s_ff + 1'b1;
               pend_in = 1'b1;
               acc_in  = move_acc;
            end else begin
               set_in = move_acc;
               acc_in = '0;
               s_in   = '0;
            end
         end
         OP_CHECK: begin
            if (set_ff == '0) begin
               dead_in = 1'b1;
            end
         end
         OP_RESULT: begin
            if (!rsp_busy) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = |(set_ff & final_n);
               rsp_died_in  = !query_ff && dead_ff;
               set_in       = '0;
               dead_in      = 1'b0;
               in_word_in   = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff       <= '0;
         s_ff         <= '0;
         pend_ff      <= 1'b0;
         changed_ff   <= 1'b0;
         dead_ff      <= 1'b0;
         in_word_ff   <= 1'b0;
         clr_ff       <= '0;
         lam_vld_ff   <= '0;
         last_ff      <= 1'b0;
         query_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         set_ff       <= set_in;
         s_ff         <= s_in;
         pend_ff      <= pend_in;
         changed_ff   <= changed_in;
         dead_ff      <= dead_in;
         in_word_ff   <= in_word_in;
         clr_ff       <= clr_in;
         lam_vld_ff   <= lam_vld_in;
         last_ff      <= last_in;
         query_ff     <= query_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rd_idx_ff   <= rd_idx_in;
      sym_idx_ff  <= sym_idx_in;
      sym_ok_ff   <= sym_ok_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_died_ff <= rsp_died_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         final_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_STATE: start_ff <= csr_data[STATE_IDX_W-1:0];
            CSR_FINAL_MASK:  final_ff <= csr_data[MASK_W-1:0];
         endcase
      end
   end

   assign csr_ready = 1'b1;

   enwa_ram #(
      .WIDTH (NUM_STATES),
      .DEPTH (SYM_DEPTH)
   ) u_sym_ram (
      .clock   (clock),
      .wr_en   (sym_we),
      .wr_addr (sym_wa),
      .wr_data (sym_wd),
      .rd_addr (sym_ra),
      .rd_data (sym_rd)
   );

   enwa_ram #(
      .WIDTH (NUM_STATES),
      .DEPTH (NUM_STATES)
   ) u_lam_ram (
      .clock   (clock),
      .wr_en   (lam_we),
      .wr_addr (req_src_idx),
      .wr_data (req_succ_n),
      .rd_addr (lam_ra),
      .rd_data (lam_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2){1'b0}}, rsp_died_ff, rsp_acc_ff};

   assign sts.accept    = req_accept;
   assign sts.func      = req_func;
   assign sts.in_word   = in_word_ff;
   assign sts.scan_done = (op == OP_CLEAR) ? clr_last : !s_lt;
   assign sts.changed   = changed_ff || close_chg;
   assign sts.query     = query_ff;
   assign sts.last      = last_ff;
   assign sts.out_busy  = rsp_busy;

endmodule
`default_nettype wire

// ----- rtl/core/epsilon_nfa_word_acceptor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsilon_nfa_word_acceptor_unit
// Word acceptor with lambda moves, run by a microcoded sequencer.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: source_state, symbol,
//                                        successor_mask; tuser: func; tlast
//   rsp      out  rsp_tvalid/rsp_tready  tdata: accepted, died_early
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// A symbol inside a word runs a move scan over the states, then one or more lambda
// closure passes until a pass leaves the set unchanged, then a check, plus the result
// when it ends the word. The first symbol of a word first builds the start closure; an
// empty-word query builds it and returns its result. After reset the symbol RAM is
// cleared one row per cycle (4096 rows at the defaults) with req_tready low; csr writes
// go through. A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module epsilon_nfa_word_acceptor_unit #(
   parameter int NUM_STATES    = enwa_pkg::DEF_NUM_STATES,
   parameter int ALPHABET_SIZE = enwa_pkg::DEF_ALPHABET_SIZE
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [3:0] source_state, [11:4] symbol, [27:12] successor_mask, [31:28] zero
   input  wire logic [enwa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] func
   input  wire logic [enwa_pkg::FUNC_W-1:0]       req_tuser,
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] accepted, [1] died_early, [7:2] zero
   output logic      [enwa_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [enwa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [enwa_pkg::CSR_DATA_W-1:0]   csr_data
);
   import enwa_pkg::*;

   op_type  op;
   sts_type sts;

   enwa_useq u_useq (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .op    (op)
   );

   enwa_dpath #(
      .NUM_STATES    (NUM_STATES),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule
`default_nettype wire
